>>> rtl/core/det_pkg.sv
// Shared types and constants for the deadline event table.
// Holds field widths, operation and result codes and the slot record type.
// Depends on nothing; every other file of the block imports it.
package det_pkg;

    localparam int SLOT_W     = 4;
    localparam int TIME_W     = 64;
    localparam int HANDLER_W  = 8;
    localparam int CONTEXT_W  = 32;
    localparam int SLOT_SPACE = 1 << SLOT_W;
    localparam int DEF_SLOTS  = 16;

    typedef enum logic [1:0] {
        FUNC_REGISTER   = 2'd0,
        FUNC_UNREGISTER = 2'd1,
        FUNC_SCHEDULE   = 2'd2,
        FUNC_TICK       = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_FIRED    = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    // One slot record: deadline, handler and context tag
    typedef struct packed {
        logic [TIME_W-1:0]    deadline;
        logic [HANDLER_W-1:0] handler;
        logic [CONTEXT_W-1:0] ctx_tag;
    } slot_entry_t;

endpackage

>>> rtl/core/det_if.sv
// Valid/ready channel interfaces of the deadline event table.
// det_cmd_if carries command transactions, det_evt_if carries result transactions.
// Depends on det_pkg.
interface det_cmd_if;
    import det_pkg::*;

    logic                 valid;
    logic                 ready;
    func_t                func;
    logic [SLOT_W-1:0]    slot;
    logic [TIME_W-1:0]    time_value;
    logic [HANDLER_W-1:0] handler_id;
    logic [CONTEXT_W-1:0] context_tag;

    modport source (
        output valid, func, slot, time_value, handler_id, context_tag,
        input  ready
    );

    modport sink (
        input  valid, func, slot, time_value, handler_id, context_tag,
        output ready
    );
endinterface

interface det_evt_if;
    import det_pkg::*;

    logic                 valid;
    logic                 ready;
    kind_t                kind;
    logic [SLOT_W-1:0]    fired_slot;
    logic [TIME_W-1:0]    fired_time;
    logic [HANDLER_W-1:0] fired_handler;
    logic [CONTEXT_W-1:0] fired_context;
    logic                 last;

    modport source (
        output valid, kind, fired_slot, fired_time, fired_handler, fired_context, last,
        input  ready
    );

    modport sink (
        input  valid, kind, fired_slot, fired_time, fired_handler, fired_context, last,
        output ready
    );
endinterface

>>> rtl/core/det_order_mem.sv
// Registration order list: one write port, one read port with registered data.
// Holds slot indices in the order they were registered.
// Depends on det_pkg for the default depth.
module det_order_mem #(
    parameter int DEPTH = det_pkg::DEF_SLOTS,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [IDX_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [IDX_W-1:0] rd_data
);
    import det_pkg::*;

    logic [IDX_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] rd_data_reg;

    // Write and read; read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/det_slot_mem.sv
// Per-slot record store: deadline, handler and context tag.
// Deadline and handler/context have separate write enables; one registered read port.
// Depends on det_pkg for slot_entry_t.
module det_slot_mem #(
    parameter int DEPTH = det_pkg::DEF_SLOTS,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_time_en,
    input  logic                wr_info_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  det_pkg::slot_entry_t wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output det_pkg::slot_entry_t rd_data
);
    import det_pkg::*;

    logic [TIME_W-1:0]    deadline_mem [DEPTH];
    logic [HANDLER_W-1:0] handler_mem  [DEPTH];
    logic [CONTEXT_W-1:0] ctx_mem      [DEPTH];
    slot_entry_t          rd_data_reg;

    // Write the selected fields, read a whole record
    always_ff @(posedge clk)
    begin
        if (wr_time_en)
        begin
            deadline_mem[wr_addr] <= wr_data.deadline;
        end
        if (wr_info_en)
        begin
            handler_mem[wr_addr] <= wr_data.handler;
            ctx_mem[wr_addr]     <= wr_data.ctx_tag;
        end
        if (rd_en)
        begin
            rd_data_reg.deadline <= deadline_mem[rd_addr];
            rd_data_reg.handler  <= handler_mem[rd_addr];
            rd_data_reg.ctx_tag  <= ctx_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/deadline_event_table.sv
// Deadline event table: top level with the operation sequencer and flags.
// Depends on det_pkg, det_if, det_order_mem and det_slot_mem.
//
// Usage:
//   cmd carries one operation per transaction: register, unregister, schedule
//   or tick. evt carries the results; last marks the final result of a command.
//   cmd.ready is high only while the sequencer is idle; one command is worked
//   on at a time.
//   Register, unregister and schedule give one result. Schedule and a rejected
//   command go from decode straight to the result state, a first-time register
//   through an append state; unregister adds a compaction pass that visits each
//   slot of the order list, and re-register adds it before the append.
//   A tick walks the order list through one shared deadline comparator, per
//   listed slot an order read state, then a record read and compare state;
//   it gives one result per fired slot, or one "nothing fired" result. The
//   record read depends on the order read, so the two are separate states.
//   Results go through an output register, so a command is taken while the
//   last result still waits. When evt stalls, the sequencer holds at the next
//   fired slot until the output register frees.
//   Reset clears the order count, the registered and armed flags and all
//   handshakes; the record memories are not cleared.
module deadline_event_table_core #(
    parameter int SLOTS = det_pkg::DEF_SLOTS
) (
    input  logic          clk,
    input  logic          rst_n,
    det_cmd_if.sink       cmd,
    det_evt_if.source     evt
);
    import det_pkg::*;

    localparam int TABLE_DEPTH = (SLOTS < SLOT_SPACE) ? SLOTS : SLOT_SPACE;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_REM    = 7'b0000100,
        S_APPEND = 7'b0001000,
        S_TSLOT  = 7'b0010000,
        S_TCMP   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    // Control state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [TABLE_DEPTH-1:0] registered_reg, registered_next;
    logic [TABLE_DEPTH-1:0] armed_reg, armed_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   evt_valid_reg, evt_valid_next;

    // Command payload
    func_t                  func_reg, func_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [HANDLER_W-1:0]   hid_reg, hid_next;
    logic [CONTEXT_W-1:0]   ctx_reg, ctx_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;

    // Pending result (held back until its last flag is known)
    kind_t                  p_kind_reg, p_kind_next;
    logic [SLOT_W-1:0]      p_slot_reg, p_slot_next;
    logic [TIME_W-1:0]      p_time_reg, p_time_next;
    logic [HANDLER_W-1:0]   p_hid_reg, p_hid_next;
    logic [CONTEXT_W-1:0]   p_ctx_reg, p_ctx_next;

    // Output register
    kind_t                  e_kind_reg;
    logic [SLOT_W-1:0]      e_slot_reg;
    logic [TIME_W-1:0]      e_time_reg;
    logic [HANDLER_W-1:0]   e_hid_reg;
    logic [CONTEXT_W-1:0]   e_ctx_reg;
    logic                   e_last_reg;

    // Memory ports
    logic                   ord_wr_en, ord_rd_en;
    logic [IDX_W-1:0]       ord_wr_addr, ord_wr_data, ord_rd_addr, ord_rd_data;
    logic                   slot_wr_time_en, slot_wr_info_en, slot_rd_en;
    logic [IDX_W-1:0]       slot_wr_addr, slot_rd_addr;
    slot_entry_t            slot_wr_data, slot_rd_data;

    logic                   cmd_accept;
    logic                   evt_free;
    logic                   load_evt, load_last;
    logic [IDX_W-1:0]       slot_idx;
    logic                   slot_in_range;
    logic                   fire;
    logic [CNT_W-1:0]       idx_inc;
    logic [CNT_W-1:0]       wr_ptr_after;

    det_order_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_order_mem (
        .clk     (clk),
        .wr_en   (ord_wr_en),
        .wr_addr (ord_wr_addr),
        .wr_data (ord_wr_data),
        .rd_en   (ord_rd_en),
        .rd_addr (ord_rd_addr),
        .rd_data (ord_rd_data)
    );

    det_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .clk        (clk),
        .wr_time_en (slot_wr_time_en),
        .wr_info_en (slot_wr_info_en),
        .wr_addr    (slot_wr_addr),
        .wr_data    (slot_wr_data),
        .rd_en      (slot_rd_en),
        .rd_addr    (slot_rd_addr),
        .rd_data    (slot_rd_data)
    );

    assign cmd.ready     = (state_reg == S_IDLE);
    assign cmd_accept    = cmd.valid && cmd.ready;
    assign evt_free      = !evt_valid_reg || evt.ready;
    assign slot_idx      = slot_reg[IDX_W-1:0];
    assign slot_in_range = (32'(slot_reg) < 32'(SLOTS));
    assign idx_inc       = idx_reg + CNT_W'(1);

    // Shared deadline comparator
    assign fire = armed_reg[cur_reg] && (slot_rd_data.deadline <= time_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        registered_next = registered_reg;
        armed_next      = armed_reg;
        pend_valid_next = pend_valid_reg;
        func_next       = func_reg;
        slot_next       = slot_reg;
        time_next       = time_reg;
        hid_next        = hid_reg;
        ctx_next        = ctx_reg;
        cur_next        = cur_reg;
        p_kind_next     = p_kind_reg;
        p_slot_next     = p_slot_reg;
        p_time_next     = p_time_reg;
        p_hid_next      = p_hid_reg;
        p_ctx_next      = p_ctx_reg;
        load_evt        = 1'b0;
        load_last       = 1'b0;
        wr_ptr_after    = wr_ptr_reg;

        ord_wr_en       = 1'b0;
        ord_wr_addr     = wr_ptr_reg[IDX_W-1:0];
        ord_wr_data     = ord_rd_data;
        ord_rd_en       = 1'b0;
        ord_rd_addr     = '0;
        slot_wr_time_en = 1'b0;
        slot_wr_info_en = 1'b0;
        slot_wr_addr    = slot_idx;
        slot_wr_data    = '{deadline: time_reg, handler: hid_reg, ctx_tag: ctx_reg};
        slot_rd_en      = 1'b0;
        slot_rd_addr    = ord_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                // Latch the command transaction
                if (cmd_accept)
                begin
                    func_next  = cmd.func;
                    slot_next  = cmd.slot;
                    time_next  = cmd.time_value;
                    hid_next   = cmd.handler_id;
                    ctx_next   = cmd.context_tag;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                idx_next        = '0;
                wr_ptr_next     = '0;
                pend_valid_next = 1'b0;
                p_kind_next     = KIND_REJECTED;
                p_slot_next     = slot_reg;
                p_time_next     = '0;
                p_hid_next      = '0;
                p_ctx_next      = '0;
                state_next      = S_EMIT;
                case (func_reg)
                    FUNC_TICK:
                    begin
                        p_kind_next = KIND_NONE;
                        p_slot_next = '0;
                        if (count_reg != '0)
                        begin
                            ord_rd_en  = 1'b1;
                            state_next = S_TSLOT;
                        end
                    end
                    FUNC_REGISTER:
                    begin
                        if (slot_in_range && (hid_reg != '0))
                        begin
                            p_kind_next               = KIND_ACCEPTED;
                            slot_wr_time_en           = 1'b1;
                            slot_wr_info_en           = 1'b1;
                            slot_wr_data.deadline     = '0;
                            registered_next[slot_idx] = 1'b1;
                            armed_next[slot_idx]      = 1'b0;
                            if (registered_reg[slot_idx])
                            begin
                                ord_rd_en  = 1'b1;
                                state_next = S_REM;
                            end
                            else
                            begin
                                state_next = S_APPEND;
                            end
                        end
                    end
                    FUNC_UNREGISTER:
                    begin
                        if (slot_in_range && registered_reg[slot_idx])
                        begin
                            p_kind_next               = KIND_ACCEPTED;
                            registered_next[slot_idx] = 1'b0;
                            armed_next[slot_idx]      = 1'b0;
                            ord_rd_en                 = 1'b1;
                            state_next                = S_REM;
                        end
                    end
                    FUNC_SCHEDULE:
                    begin
                        if (slot_in_range && registered_reg[slot_idx])
                        begin
                            p_kind_next          = KIND_ACCEPTED;
                            armed_next[slot_idx] = 1'b1;
                            slot_wr_time_en      = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_REM:
            begin
                // Compact the order list, dropping the addressed slot
                if (ord_rd_data != slot_idx)
                begin
                    ord_wr_en    = 1'b1;
                    wr_ptr_after = wr_ptr_reg + CNT_W'(1);
                end
                wr_ptr_next = wr_ptr_after;
                if (idx_inc < count_reg)
                begin
                    ord_rd_en   = 1'b1;
                    ord_rd_addr = idx_inc[IDX_W-1:0];
                    idx_next    = idx_inc;
                end
                else
                begin
                    count_next = wr_ptr_after;
                    state_next = (func_reg == FUNC_REGISTER) ? S_APPEND : S_EMIT;
                end
            end

            S_APPEND:
            begin
                // Append the slot at the end of the order
                if (count_reg < CNT_W'(TABLE_DEPTH))
                begin
                    ord_wr_en   = 1'b1;
                    ord_wr_addr = count_reg[IDX_W-1:0];
                    ord_wr_data = slot_idx;
                    count_next  = count_reg + CNT_W'(1);
                end
                state_next = S_EMIT;
            end

            S_TSLOT:
            begin
                // Fetch the record of the next listed slot
                cur_next   = ord_rd_data;
                slot_rd_en = 1'b1;
                state_next = S_TCMP;
            end

            S_TCMP:
            begin
                // Hold while a fired result cannot pass the previous one out
                if (!fire || !pend_valid_reg || evt_free)
                begin
                    if (fire)
                    begin
                        load_evt             = pend_valid_reg;
                        pend_valid_next      = 1'b1;
                        p_kind_next          = KIND_FIRED;
                        p_slot_next          = SLOT_W'(cur_reg);
                        p_time_next          = slot_rd_data.deadline;
                        p_hid_next           = slot_rd_data.handler;
                        p_ctx_next           = slot_rd_data.ctx_tag;
                        armed_next[cur_reg]  = 1'b0;
                    end
                    if (idx_inc < count_reg)
                    begin
                        ord_rd_en   = 1'b1;
                        ord_rd_addr = idx_inc[IDX_W-1:0];
                        idx_next    = idx_inc;
                        state_next  = S_TSLOT;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                // Hand over the final result of the command
                if (evt_free)
                begin
                    load_evt   = 1'b1;
                    load_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign evt_valid_next = load_evt || (evt_valid_reg && !evt.ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            wr_ptr_reg     <= '0;
            registered_reg <= '0;
            armed_reg      <= '0;
            pend_valid_reg <= 1'b0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            wr_ptr_reg     <= wr_ptr_next;
            registered_reg <= registered_next;
            armed_reg      <= armed_next;
            pend_valid_reg <= pend_valid_next;
            evt_valid_reg  <= evt_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        slot_reg   <= slot_next;
        time_reg   <= time_next;
        hid_reg    <= hid_next;
        ctx_reg    <= ctx_next;
        cur_reg    <= cur_next;
        p_kind_reg <= p_kind_next;
        p_slot_reg <= p_slot_next;
        p_time_reg <= p_time_next;
        p_hid_reg  <= p_hid_next;
        p_ctx_reg  <= p_ctx_next;
        if (load_evt)
        begin
            e_kind_reg <= p_kind_reg;
            e_slot_reg <= p_slot_reg;
            e_time_reg <= p_time_reg;
            e_hid_reg  <= p_hid_reg;
            e_ctx_reg  <= p_ctx_reg;
            e_last_reg <= load_last;
        end
    end

    assign evt.valid         = evt_valid_reg;
    assign evt.kind          = e_kind_reg;
    assign evt.fired_slot    = e_slot_reg;
    assign evt.fired_time    = e_time_reg;
    assign evt.fired_handler = e_hid_reg;
    assign evt.fired_context = e_ctx_reg;
    assign evt.last          = e_last_reg;

endmodule

>>> rtl/core/det_checker.sv
// Port-level checks for the deadline event table, bound to the top level.
// Watches the command and result channels only.
// Depends on det_pkg for result codes.
module det_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cmd_valid,
    input logic                     cmd_ready,
    input logic                     evt_valid,
    input logic                     evt_ready,
    input logic [1:0]               evt_kind,
    input logic [det_pkg::SLOT_W-1:0] evt_fired_slot,
    input logic [det_pkg::TIME_W-1:0] evt_fired_time,
    input logic                     evt_last
);
    import det_pkg::*;

    // One command at a time: no new transaction right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command taken while previous one still in work");

    // A tick that is still emitting keeps the command side closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_last) |-> !cmd_ready)
        else $error("command port open during a multi-result tick");

    // An empty tick result is final and carries no slot or deadline
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && (evt_kind == KIND_NONE))
            |-> (evt_last && (evt_fired_slot == '0) && (evt_fired_time == '0)))
        else $error("malformed empty tick result");

    // Accepted or rejected commands give a single, final, timeless result
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && ((evt_kind == KIND_ACCEPTED) || (evt_kind == KIND_REJECTED)))
            |-> (evt_last && (evt_fired_time == '0)))
        else $error("status result not final");

    // Hold a stalled result transaction unchanged until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_ready)
            |=> (evt_valid && $stable(evt_kind) && $stable(evt_fired_slot)
                 && $stable(evt_fired_time) && $stable(evt_last)))
        else $error("stalled result changed or dropped");

endmodule

bind deadline_event_table_core det_checker u_det_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .evt_valid      (evt.valid),
    .evt_ready      (evt.ready),
    .evt_kind       (evt.kind),
    .evt_fired_slot (evt.fired_slot),
    .evt_fired_time (evt.fired_time),
    .evt_last       (evt.last)
);
